### hw/rtl/rttoff_pkg.sv
// Shared constants, types and state codes for the RTT and clock offset estimator.
// Used by rtt_and_clock_offset_estimator_core, rttoff_checker, rttoff_scoreboard and tb.
package rttoff_pkg;

   localparam int RING_DEPTH    = 32;
   localparam int OFFSET_WINDOW = 16;
   localparam int TIME_BITS     = 48;

   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int WIN_AW     = (OFFSET_WINDOW > 1) ? $clog2(OFFSET_WINDOW) : 1;
   localparam int SEQ_W      = 16;
   localparam int AGE_W      = 16;
   localparam int RTT_W      = 24;
   localparam int OFF_W      = 50;
   localparam int FILL_W     = 5;
   localparam int ALPHA_W    = 16;
   localparam int CLAMP_W    = 21;
   localparam int FRAC_W     = 16;
   localparam int SM_W       = RTT_W + FRAC_W;
   localparam int PROD_W     = SM_W + ALPHA_W;
   localparam int AGE_US_W   = 26;
   localparam int SUM_W      = AGE_US_W + 1;
   localparam int RAW_W      = AGE_US_W + 2;
   localparam int MS_W       = 10;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [MS_W-1:0]    MS_TO_US       = 10'd1000;
   localparam logic [AGE_W-1:0]   RST_MAX_AGE    = 16'd1000;
   localparam logic [CLAMP_W-1:0] RST_NEG_CLAMP  = 21'h1FEC78;
   localparam logic [RTT_W-1:0]   RST_MAX_PLAUS  = 24'd1000000;
   localparam logic [ALPHA_W-1:0] RST_ALPHA      = 16'd8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_AGE   = 4'd0,
      CSR_NEG_CLAMP = 4'd1,
      CSR_MAX_PLAUS = 4'd2,
      CSR_ALPHA     = 4'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIFF,
      ST_RANGE,
      ST_CLAMP,
      ST_EW_DIFF,
      ST_EW_MUL,
      ST_EW_ADD,
      ST_WIN_WR,
      ST_WIN_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]     seq;
      logic [TIME_BITS-1:0] stamp;
   } ring_word_type;

   typedef struct packed {
      logic [RTT_W-1:0] rtt;
      logic [OFF_W-1:0] offset;
   } win_word_type;

endpackage

### hw/rtl/rtt_and_clock_offset_estimator_core.sv
// RTT and clock offset estimator, top level.
// Depends on rttoff_pkg (constants, types, state codes).
//
// Usage:
//   req_* carries one beat per event: func 0 records a sent packet (sequence number and
//   send time) in a 32-entry ring; func 1 is a telemetry echo that is matched against the
//   ring, turned into an RTT sample, folded into an EWMA and a running minimum, and, if it
//   carries a build timestamp, into a 16-entry clock offset window.
//   rsp_* returns exactly one beat per request beat, in order.
//   csr_* writes the four tuning registers; write them only while the block is idle.
//   Flow: a send beat, or a telemetry beat dropped on its echo flag or age, is answered in
//   the cycle after acceptance. Other telemetry beats walk the ring one entry per cycle
//   until a match or the last entry; a matched beat then passes the difference, range and
//   clamp steps and, unless rejected, the EWMA difference, multiply and update steps and,
//   with a build timestamp, a window write plus a scan of the filled window entries, and
//   the response is then presented. In the worst case the ring search takes the longest.
//   One beat is in flight at a time: req_stall is high from acceptance until the response
//   beat is taken, and the next beat can be taken in the following cycle. While rsp_stall
//   is high the response holds unchanged.
//   Reset clears the registers to their defaults, empties the ring and the window and
//   drops any beat in flight. No clearing pass is needed.
module rtt_and_clock_offset_estimator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [rttoff_pkg::SEQ_W-1:0]           req_seq,
   input  logic [rttoff_pkg::TIME_BITS-1:0]       req_time_us,
   input  logic                                   req_echo_ok,
   input  logic [rttoff_pkg::AGE_W-1:0]           req_age_ms,
   input  logic [rttoff_pkg::TIME_BITS-1:0]       req_build_pts_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic [rttoff_pkg::RTT_W-1:0]           rsp_sample_rtt_us,
   output logic                                   rsp_have_rtt,
   output logic [rttoff_pkg::RTT_W-1:0]           rsp_rtt_smoothed_us,
   output logic [rttoff_pkg::RTT_W-1:0]           rsp_rtt_lowest_us,
   output logic signed [rttoff_pkg::OFF_W-1:0]    rsp_clock_offset_us,
   output logic [rttoff_pkg::FILL_W-1:0]          rsp_offset_count,
   input  logic                                   csr_wr_en,
   input  logic [rttoff_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rttoff_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [rttoff_pkg::RING_AW-1:0] RING_LAST =
      rttoff_pkg::RING_AW'(rttoff_pkg::RING_DEPTH - 1);
   localparam logic [rttoff_pkg::WIN_AW-1:0] WIN_LAST =
      rttoff_pkg::WIN_AW'(rttoff_pkg::OFFSET_WINDOW - 1);
   localparam logic [rttoff_pkg::FILL_W-1:0] FILL_MAX =
      rttoff_pkg::FILL_W'(rttoff_pkg::OFFSET_WINDOW);

   rttoff_pkg::state_type state_ff, state_in;

   logic [rttoff_pkg::AGE_W-1:0]     max_age_ff;
   logic [rttoff_pkg::CLAMP_W-1:0]   neg_clamp_ff;
   logic [rttoff_pkg::RTT_W-1:0]     max_plaus_ff;
   logic [rttoff_pkg::ALPHA_W-1:0]   alpha_ff;

   rttoff_pkg::ring_word_type        ring_mem [rttoff_pkg::RING_DEPTH];
   rttoff_pkg::ring_word_type        ring_rd_ff;
   logic [rttoff_pkg::RING_DEPTH-1:0] used_ff;
   logic [rttoff_pkg::RING_AW-1:0]   ring_wptr_ff;
   logic [rttoff_pkg::RING_AW-1:0]   ring_idx_ff;
   logic [rttoff_pkg::RING_AW-1:0]   ring_probe_idx_ff;
   logic                             probe_vld_ff;

   logic [rttoff_pkg::SEQ_W-1:0]     seq_ff;
   logic [rttoff_pkg::TIME_BITS-1:0] rx_ff;
   logic [rttoff_pkg::TIME_BITS-1:0] build_ff;
   logic [rttoff_pkg::AGE_US_W-1:0]  age_us_ff;
   logic [rttoff_pkg::TIME_BITS-1:0] hit_time_ff;
   logic [rttoff_pkg::TIME_BITS-1:0] diff_ff;
   logic                             late_ff;
   logic                             too_big_ff;
   logic signed [rttoff_pkg::RAW_W-1:0] raw_ff;
   logic [rttoff_pkg::RTT_W-1:0]     rtt_ff;
   logic                             first_ff;
   logic                             dir_up_ff;
   logic [rttoff_pkg::SM_W-1:0]      delta_ff;
   logic [rttoff_pkg::OFF_W-1:0]     bm_ff;
   logic [rttoff_pkg::PROD_W-1:0]    prod_ff;
   logic [rttoff_pkg::OFF_W-1:0]     off_ff;

   logic [rttoff_pkg::SM_W-1:0]      smoothed_ff;
   logic [rttoff_pkg::RTT_W-1:0]     lowest_ff;
   logic                             have_ff;
   logic                             accepted_ff;
   logic [rttoff_pkg::RTT_W-1:0]     sample_ff;

   rttoff_pkg::win_word_type         win_mem [rttoff_pkg::OFFSET_WINDOW];
   rttoff_pkg::win_word_type         win_rd_ff;
   logic [rttoff_pkg::WIN_AW-1:0]    win_wptr_ff;
   logic [rttoff_pkg::WIN_AW-1:0]    win_idx_ff;
   logic [rttoff_pkg::WIN_AW-1:0]    win_probe_idx_ff;
   logic [rttoff_pkg::FILL_W-1:0]    fill_ff;
   logic [rttoff_pkg::RTT_W-1:0]     best_rtt_ff;
   logic [rttoff_pkg::OFF_W-1:0]     best_off_ff;

   logic                             accept_in;
   logic                             age_ok;
   logic                             ring_match;
   logic                             ring_last;
   logic [rttoff_pkg::SUM_W-1:0]     range_sum;
   logic signed [rttoff_pkg::RAW_W-1:0] clamp_ext;
   logic signed [rttoff_pkg::RAW_W-1:0] plaus_ext;
   logic                             reject;
   logic [rttoff_pkg::SM_W-1:0]      target;
   logic                             win_last;
   logic                             win_better;

   assign accept_in  = req_valid && !req_stall;
   assign age_ok     = req_echo_ok && (req_age_ms < max_age_ff);
   assign ring_match = probe_vld_ff && used_ff[ring_probe_idx_ff] &&
                       (ring_rd_ff.seq == seq_ff);
   assign ring_last  = (ring_probe_idx_ff == RING_LAST);
   assign range_sum  = rttoff_pkg::SUM_W'(max_plaus_ff) + rttoff_pkg::SUM_W'(age_us_ff);
   assign clamp_ext  = {{(rttoff_pkg::RAW_W - rttoff_pkg::CLAMP_W){neg_clamp_ff[rttoff_pkg::CLAMP_W-1]}},
                        neg_clamp_ff};
   assign plaus_ext  = {{(rttoff_pkg::RAW_W - rttoff_pkg::RTT_W){1'b0}}, max_plaus_ff};
   assign reject     = late_ff || too_big_ff || (raw_ff < clamp_ext) || (raw_ff > plaus_ext);
   assign target     = {rtt_ff, {rttoff_pkg::FRAC_W{1'b0}}};
   assign win_last   = (rttoff_pkg::FILL_W'(win_probe_idx_ff) ==
                        (fill_ff - rttoff_pkg::FILL_W'(1)));
   assign win_better = (win_probe_idx_ff == '0) || (win_rd_ff.rtt < best_rtt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rttoff_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rttoff_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept_in) begin
               if (req_func && age_ok) begin
                  state_in = rttoff_pkg::ST_SEARCH;
               end else begin
                  state_in = rttoff_pkg::ST_RESP;
               end
            end
         end
         rttoff_pkg::ST_SEARCH: begin
            if (ring_match) begin
               state_in = rttoff_pkg::ST_DIFF;
            end else if (probe_vld_ff && ring_last) begin
               state_in = rttoff_pkg::ST_RESP;
            end
         end
         rttoff_pkg::ST_DIFF:    state_in = rttoff_pkg::ST_RANGE;
         rttoff_pkg::ST_RANGE:   state_in = rttoff_pkg::ST_CLAMP;
         rttoff_pkg::ST_CLAMP:   state_in = reject ? rttoff_pkg::ST_RESP : rttoff_pkg::ST_EW_DIFF;
         rttoff_pkg::ST_EW_DIFF: state_in = rttoff_pkg::ST_EW_MUL;
         rttoff_pkg::ST_EW_MUL:  state_in = rttoff_pkg::ST_EW_ADD;
         rttoff_pkg::ST_EW_ADD: begin
            state_in = (build_ff != '0) ? rttoff_pkg::ST_WIN_WR : rttoff_pkg::ST_RESP;
         end
         rttoff_pkg::ST_WIN_WR:  state_in = rttoff_pkg::ST_WIN_SCAN;
         rttoff_pkg::ST_WIN_SCAN: begin
            if (probe_vld_ff && win_last) begin
               state_in = rttoff_pkg::ST_RESP;
            end
         end
         rttoff_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = rttoff_pkg::ST_IDLE;
            end
         end
         default: state_in = rttoff_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= rttoff_pkg::RST_MAX_AGE;
         neg_clamp_ff <= rttoff_pkg::RST_NEG_CLAMP;
         max_plaus_ff <= rttoff_pkg::RST_MAX_PLAUS;
         alpha_ff     <= rttoff_pkg::RST_ALPHA;
         used_ff      <= '0;
         ring_wptr_ff <= '0;
         smoothed_ff  <= '0;
         lowest_ff    <= '0;
         have_ff      <= 1'b0;
         win_wptr_ff  <= '0;
         fill_ff      <= '0;
         best_off_ff  <= '0;
         probe_vld_ff <= 1'b0;
         accepted_ff  <= 1'b0;
         sample_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               rttoff_pkg::CSR_MAX_AGE:   max_age_ff   <= csr_wdata[rttoff_pkg::AGE_W-1:0];
               rttoff_pkg::CSR_NEG_CLAMP: neg_clamp_ff <= csr_wdata[rttoff_pkg::CLAMP_W-1:0];
               rttoff_pkg::CSR_MAX_PLAUS: max_plaus_ff <= csr_wdata[rttoff_pkg::RTT_W-1:0];
               rttoff_pkg::CSR_ALPHA:     alpha_ff     <= csr_wdata[rttoff_pkg::ALPHA_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            rttoff_pkg::ST_IDLE: begin
               if (accept_in) begin
                  seq_ff       <= req_seq;
                  rx_ff        <= req_time_us;
                  build_ff     <= req_build_pts_us;
                  age_us_ff    <= rttoff_pkg::AGE_US_W'(req_age_ms) *
                                  rttoff_pkg::AGE_US_W'(rttoff_pkg::MS_TO_US);
                  accepted_ff  <= 1'b0;
                  sample_ff    <= '0;
                  ring_idx_ff  <= '0;
                  probe_vld_ff <= 1'b0;
                  if (!req_func) begin
                     used_ff[ring_wptr_ff] <= 1'b1;
                     ring_wptr_ff <= (ring_wptr_ff == RING_LAST) ? '0
                                     : ring_wptr_ff + rttoff_pkg::RING_AW'(1);
                  end
               end
            end
            rttoff_pkg::ST_SEARCH: begin
               ring_probe_idx_ff <= ring_idx_ff;
               probe_vld_ff      <= 1'b1;
               if (ring_idx_ff != RING_LAST) begin
                  ring_idx_ff <= ring_idx_ff + rttoff_pkg::RING_AW'(1);
               end
               if (ring_match) begin
                  hit_time_ff <= ring_rd_ff.stamp;
               end
            end
            rttoff_pkg::ST_DIFF: begin
               late_ff <= (rx_ff < hit_time_ff);
               diff_ff <= rx_ff - hit_time_ff;
            end
            rttoff_pkg::ST_RANGE: begin
               too_big_ff <= (diff_ff[rttoff_pkg::TIME_BITS-1:rttoff_pkg::SUM_W] != '0) ||
                             (diff_ff[rttoff_pkg::SUM_W-1:0] > range_sum);
               raw_ff <= signed'(rttoff_pkg::RAW_W'(diff_ff[rttoff_pkg::SUM_W-1:0])) -
                         signed'(rttoff_pkg::RAW_W'(age_us_ff));
            end
            rttoff_pkg::ST_CLAMP: begin
               if (!reject) begin
                  accepted_ff <= 1'b1;
                  rtt_ff    <= raw_ff[rttoff_pkg::RAW_W-1] ? '0 : raw_ff[rttoff_pkg::RTT_W-1:0];
                  sample_ff <= raw_ff[rttoff_pkg::RAW_W-1] ? '0 : raw_ff[rttoff_pkg::RTT_W-1:0];
               end
            end
            rttoff_pkg::ST_EW_DIFF: begin
               first_ff  <= !have_ff;
               dir_up_ff <= (target >= smoothed_ff);
               delta_ff  <= (target >= smoothed_ff) ? target - smoothed_ff
                                                    : smoothed_ff - target;
               bm_ff     <= rttoff_pkg::OFF_W'(build_ff) - rttoff_pkg::OFF_W'(rx_ff);
            end
            rttoff_pkg::ST_EW_MUL: begin
               prod_ff <= delta_ff * alpha_ff;
               off_ff  <= bm_ff + rttoff_pkg::OFF_W'(rtt_ff[rttoff_pkg::RTT_W-1:1]);
            end
            rttoff_pkg::ST_EW_ADD: begin
               if (first_ff) begin
                  smoothed_ff <= target;
                  lowest_ff   <= rtt_ff;
                  have_ff     <= 1'b1;
               end else begin
                  smoothed_ff <= dir_up_ff
                     ? smoothed_ff + prod_ff[rttoff_pkg::PROD_W-1:rttoff_pkg::FRAC_W]
                     : smoothed_ff - prod_ff[rttoff_pkg::PROD_W-1:rttoff_pkg::FRAC_W];
                  if (rtt_ff < lowest_ff) begin
                     lowest_ff <= rtt_ff;
                  end
               end
               probe_vld_ff <= 1'b0;
               win_idx_ff   <= '0;
            end
            rttoff_pkg::ST_WIN_WR: begin
               win_wptr_ff <= (win_wptr_ff == WIN_LAST) ? '0
                              : win_wptr_ff + rttoff_pkg::WIN_AW'(1);
               if (fill_ff != FILL_MAX) begin
                  fill_ff <= fill_ff + rttoff_pkg::FILL_W'(1);
               end
            end
            rttoff_pkg::ST_WIN_SCAN: begin
               win_probe_idx_ff <= win_idx_ff;
               probe_vld_ff     <= 1'b1;
               if (win_idx_ff != WIN_LAST) begin
                  win_idx_ff <= win_idx_ff + rttoff_pkg::WIN_AW'(1);
               end
               if (probe_vld_ff && win_better) begin
                  best_rtt_ff <= win_rd_ff.rtt;
                  best_off_ff <= win_rd_ff.offset;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rttoff_pkg::ST_IDLE && accept_in && !req_func) begin
         ring_mem[ring_wptr_ff] <= '{seq: req_seq, stamp: req_time_us};
      end
      ring_rd_ff <= ring_mem[ring_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == rttoff_pkg::ST_WIN_WR) begin
         win_mem[win_wptr_ff] <= '{rtt: rtt_ff, offset: off_ff};
      end
      win_rd_ff <= win_mem[win_idx_ff];
   end

   assign rsp_accepted        = accepted_ff;
   assign rsp_sample_rtt_us   = sample_ff;
   assign rsp_have_rtt        = have_ff;
   assign rsp_rtt_smoothed_us = smoothed_ff[rttoff_pkg::SM_W-1:rttoff_pkg::FRAC_W];
   assign rsp_rtt_lowest_us   = lowest_ff;
   assign rsp_clock_offset_us = signed'(best_off_ff);
   assign rsp_offset_count    = fill_ff;

endmodule

### hw/rtl/rttoff_checker.sv
// Port-level checks for rtt_and_clock_offset_estimator_core, attached with bind.
// Depends on rttoff_pkg for widths and on the top level's port list.
module rttoff_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_accepted,
   input logic [rttoff_pkg::RTT_W-1:0]        rsp_sample_rtt_us,
   input logic                                rsp_have_rtt,
   input logic [rttoff_pkg::RTT_W-1:0]        rsp_rtt_lowest_us,
   input logic signed [rttoff_pkg::OFF_W-1:0] rsp_clock_offset_us
);

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a beat is in flight");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while a response waits");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_sample_rtt_us == '0))
      else $error("rejected beat reports a nonzero sample");

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |->
         (rsp_have_rtt && (rsp_rtt_lowest_us <= rsp_sample_rtt_us)))
      else $error("accepted sample not reflected in minimum");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_clock_offset_us)))
      else $error("stalled response beat changed");

endmodule

bind rtt_and_clock_offset_estimator_core rttoff_checker u_rttoff_checker (.*);

### tb/rttoff_checker.sv
// Scoreboard for rtt_and_clock_offset_estimator_core: watches req, rsp and csr beats,
// keeps its own ring, EWMA, minimum and offset window, and compares every response beat.
// Depends on rttoff_pkg for widths, reset values and register codes.
module rttoff_scoreboard
   import rttoff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_func,
   input  logic [SEQ_W-1:0]      req_seq,
   input  logic [TIME_BITS-1:0]  req_time_us,
   input  logic                  req_echo_ok,
   input  logic [AGE_W-1:0]      req_age_ms,
   input  logic [TIME_BITS-1:0]  req_build_pts_us,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_accepted,
   input  logic [RTT_W-1:0]      rsp_sample_rtt_us,
   input  logic                  rsp_have_rtt,
   input  logic [RTT_W-1:0]      rsp_rtt_smoothed_us,
   input  logic [RTT_W-1:0]      rsp_rtt_lowest_us,
   input  logic [OFF_W-1:0]      rsp_clock_offset_us,
   input  logic [FILL_W-1:0]     rsp_offset_count,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    in_flight,
   output int                    rtt_samples
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              accepted;
      logic [RTT_W-1:0]  sample;
      logic              have;
      logic [RTT_W-1:0]  smoothed;
      logic [RTT_W-1:0]  lowest;
      logic [OFF_W-1:0]  offset;
      logic [FILL_W-1:0] fill;
   } estimate_type;

   estimate_type estimates_due [$];

   logic [AGE_W-1:0]     cfg_max_age;
   logic [CLAMP_W-1:0]   cfg_clamp;
   logic [RTT_W-1:0]     cfg_max_plaus;
   logic [ALPHA_W-1:0]   cfg_alpha;

   logic [SEQ_W-1:0]     ring_seq [RING_DEPTH];
   logic [TIME_BITS-1:0] ring_stamp [RING_DEPTH];
   logic                 ring_used [RING_DEPTH];
   int                   ring_wp;
   logic [SM_W-1:0]      smoothed;
   logic [RTT_W-1:0]     lowest;
   logic                 have_sample;
   logic [RTT_W-1:0]     win_rtt [OFFSET_WINDOW];
   logic [OFF_W-1:0]     win_offset [OFFSET_WINDOW];
   int                   win_wp;
   int                   win_fill;

   function automatic void clear_estimator();
      cfg_max_age   = RST_MAX_AGE;
      cfg_clamp     = RST_NEG_CLAMP;
      cfg_max_plaus = RST_MAX_PLAUS;
      cfg_alpha     = RST_ALPHA;
      foreach (ring_used[i]) ring_used[i] = 1'b0;
      foreach (win_rtt[i]) begin
         win_rtt[i]    = '0;
         win_offset[i] = '0;
      end
      ring_wp     = 0;
      smoothed    = '0;
      lowest      = '0;
      have_sample = 1'b0;
      win_wp      = 0;
      win_fill    = 0;
   endfunction

   function automatic bit fold_echo(input logic [SEQ_W-1:0] seq,
                                    input logic [TIME_BITS-1:0] rx,
                                    input logic echo,
                                    input logic [AGE_W-1:0] age,
                                    input logic [TIME_BITS-1:0] build,
                                    output logic [RTT_W-1:0] rtt);
      int hit;
      logic [63:0] diff, age_us, target;
      longint raw;
      rtt = '0;
      hit = -1;
      if (!echo || age >= cfg_max_age) return 1'b0;
      for (int i = RING_DEPTH - 1; i >= 0; i--)
         if (ring_used[i] && ring_seq[i] == seq) hit = i;
      if (hit < 0) return 1'b0;
      if (rx < ring_stamp[hit]) return 1'b0;
      diff   = 64'(rx) - 64'(ring_stamp[hit]);
      age_us = 64'(age) * 64'(MS_TO_US);
      if (diff > 64'(cfg_max_plaus) + age_us) return 1'b0;
      raw = longint'(diff) - longint'(age_us);
      if (raw < longint'($signed(cfg_clamp)) || raw > longint'(cfg_max_plaus)) return 1'b0;
      rtt    = (raw < 0) ? '0 : RTT_W'(raw);
      target = 64'(rtt) << FRAC_W;
      if (!have_sample) begin
         smoothed    = SM_W'(target);
         lowest      = rtt;
         have_sample = 1'b1;
      end else begin
         if (target >= 64'(smoothed))
            smoothed = SM_W'(64'(smoothed)
                             + (((target - 64'(smoothed)) * 64'(cfg_alpha)) >> FRAC_W));
         else
            smoothed = SM_W'(64'(smoothed)
                             - (((64'(smoothed) - target) * 64'(cfg_alpha)) >> FRAC_W));
         if (rtt < lowest) lowest = rtt;
      end
      if (build != '0) begin
         win_rtt[win_wp]    = rtt;
         win_offset[win_wp] = OFF_W'(64'(build) - 64'(rx) + 64'(rtt >> 1));
         win_wp = (win_wp + 1) % OFFSET_WINDOW;
         if (win_fill < OFFSET_WINDOW) win_fill++;
      end
      return 1'b1;
   endfunction

   function automatic estimate_type estimate_beat(input logic func,
                                                  input logic [SEQ_W-1:0] seq,
                                                  input logic [TIME_BITS-1:0] stamp,
                                                  input logic echo,
                                                  input logic [AGE_W-1:0] age,
                                                  input logic [TIME_BITS-1:0] build);
      estimate_type est;
      logic [RTT_W-1:0] rtt;
      bit took;
      int best;
      took = 1'b0;
      rtt  = '0;
      if (!func) begin
         ring_seq[ring_wp]   = seq;
         ring_stamp[ring_wp] = stamp;
         ring_used[ring_wp]  = 1'b1;
         ring_wp = (ring_wp + 1) % RING_DEPTH;
      end else begin
         took = fold_echo(seq, stamp, echo, age, build, rtt);
      end
      best = 0;
      for (int i = 1; i < win_fill; i++)
         if (win_rtt[i] < win_rtt[best]) best = i;
      est.accepted = took;
      est.sample   = took ? rtt : '0;
      est.have     = have_sample;
      est.smoothed = smoothed[SM_W-1:FRAC_W];
      est.lowest   = lowest;
      est.offset   = win_offset[best];
      est.fill     = FILL_W'(win_fill);
      if (took) rtt_samples++;
      return est;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      estimate_type due;
      if (reset) begin
         clear_estimator();
         estimates_due.delete();
         mismatches  = 0;
         rtt_samples = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (estimates_due.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               due = estimates_due.pop_front();
               check_field("accepted", due.accepted, rsp_accepted);
               check_field("sample_rtt_us", due.sample, rsp_sample_rtt_us);
               check_field("have_rtt", due.have, rsp_have_rtt);
               check_field("rtt_smoothed_us", due.smoothed, rsp_rtt_smoothed_us);
               check_field("rtt_lowest_us", due.lowest, rsp_rtt_lowest_us);
               check_field("clock_offset_us", due.offset, rsp_clock_offset_us);
               check_field("offset_count", due.fill, rsp_offset_count);
            end
         end
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_MAX_AGE:   cfg_max_age   = csr_wdata[AGE_W-1:0];
               CSR_NEG_CLAMP: cfg_clamp     = csr_wdata[CLAMP_W-1:0];
               CSR_MAX_PLAUS: cfg_max_plaus = csr_wdata[RTT_W-1:0];
               CSR_ALPHA:     cfg_alpha     = csr_wdata[ALPHA_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            estimates_due.push_back(estimate_beat(req_func, req_seq, req_time_us,
                                                  req_echo_ok, req_age_ms,
                                                  req_build_pts_us));
      end
      in_flight = estimates_due.size();
   end

endmodule

### tb/tb.sv
// Top of the estimator testbench: clock, reset, send and telemetry stimulus, register
// settings and the verdict. Depends on rttoff_pkg, rtt_and_clock_offset_estimator_core
// and rttoff_scoreboard.
module tb;
   import rttoff_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASES       = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd9;

   typedef struct {
      logic                 func;
      logic [SEQ_W-1:0]     seq;
      logic [TIME_BITS-1:0] time_us;
      logic                 echo_ok;
      logic [AGE_W-1:0]     age_ms;
      logic [TIME_BITS-1:0] build_pts_us;
   } packet_event_type;

   typedef struct {
      int unsigned max_age;
      longint      clamp;
      int unsigned max_plaus;
      int unsigned alpha;
      int          beats;
   } tuning_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_func = 1'b0;
   logic [SEQ_W-1:0]             req_seq = '0;
   logic [TIME_BITS-1:0]         req_time_us = '0;
   logic                         req_echo_ok = 1'b0;
   logic [AGE_W-1:0]             req_age_ms = '0;
   logic [TIME_BITS-1:0]         req_build_pts_us = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_accepted;
   logic [RTT_W-1:0]             rsp_sample_rtt_us;
   logic                         rsp_have_rtt;
   logic [RTT_W-1:0]             rsp_rtt_smoothed_us;
   logic [RTT_W-1:0]             rsp_rtt_lowest_us;
   logic signed [OFF_W-1:0]      rsp_clock_offset_us;
   logic [FILL_W-1:0]            rsp_offset_count;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   int mismatches, in_flight, rtt_samples;
   int quiet;
   int sent_total, echo_total;
   bit calm = 1'b0;
   tuning_type tuning;
   logic [TIME_BITS-1:0] now_us;
   logic [SEQ_W-1:0]     sent_seq [RING_DEPTH];
   logic [TIME_BITS-1:0] sent_at [RING_DEPTH];

   rtt_and_clock_offset_estimator_core dut (.*);
   rttoff_scoreboard scoreboard (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) rsp_stall <= !calm && ($urandom_range(99) < 19);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [TIME_BITS-1:0] rand_stamp();
      return TIME_BITS'({$urandom, $urandom});
   endfunction

   function automatic packet_event_type send_event(input logic [SEQ_W-1:0] seq,
                                                   input logic [TIME_BITS-1:0] stamp);
      packet_event_type e;
      e.func         = 1'b0;
      e.seq          = seq;
      e.time_us      = stamp;
      e.echo_ok      = 1'($urandom_range(1));
      e.age_ms       = AGE_W'($urandom);
      e.build_pts_us = rand_stamp();
      sent_seq[sent_total % RING_DEPTH] = seq;
      sent_at[sent_total % RING_DEPTH]  = stamp;
      sent_total++;
      return e;
   endfunction

   function automatic packet_event_type echo_event(input logic [SEQ_W-1:0] seq,
                                                   input logic [TIME_BITS-1:0] sent,
                                                   input logic [AGE_W-1:0] age,
                                                   input longint raw,
                                                   input logic [TIME_BITS-1:0] build);
      packet_event_type e;
      e.func         = 1'b1;
      e.seq          = seq;
      e.time_us      = TIME_BITS'(64'(sent) + 64'(age) * 64'd1000 + 64'(raw));
      e.echo_ok      = 1'b1;
      e.age_ms       = age;
      e.build_pts_us = build;
      return e;
   endfunction

   function automatic packet_event_type random_event();
      packet_event_type e;
      int unsigned pick, slot, age_top;
      logic [SEQ_W-1:0] seq;
      logic [AGE_W-1:0] age;
      logic [TIME_BITS-1:0] build;
      longint raw;
      pick  = $urandom_range(99);
      build = ($urandom_range(4) == 0) ? '0 : rand_stamp();
      if (pick < 40 || sent_total == 0) begin
         now_us = now_us + $urandom_range(5000, 1);
         seq = ($urandom_range(9) == 0 && sent_total > 0) ? sent_seq[0] : SEQ_W'($urandom);
         return send_event(seq, now_us);
      end
      if (pick < 88) begin
         slot    = $urandom_range((sent_total < RING_DEPTH ? sent_total : RING_DEPTH) - 1);
         age_top = (tuning.max_age == 0) ? 0 : tuning.max_age - 1;
         age = ($urandom_range(2) == 0) ? $urandom_range(age_top)
                                        : $urandom_range(age_top < 50 ? age_top : 50);
         case ($urandom_range(5))
            0: raw = $urandom_range(tuning.max_plaus < 3000 ? tuning.max_plaus : 3000);
            1: raw = $urandom_range(tuning.max_plaus);
            2: raw = longint'(tuning.max_plaus) - 1 + $urandom_range(2);
            3: raw = tuning.clamp - 1 + $urandom_range(2);
            4: raw = (tuning.clamp < 0) ? -longint'($urandom_range(-tuning.clamp)) : 0;
            default: raw = 0;
         endcase
         return echo_event(sent_seq[slot], sent_at[slot], age, raw, build);
      end
      e.func         = 1'b1;
      e.seq          = $urandom_range(1) ? sent_seq[$urandom_range(RING_DEPTH - 1)]
                                         : SEQ_W'($urandom);
      e.time_us      = $urandom_range(1) ? rand_stamp()
                                         : now_us + $urandom_range(2000000);
      e.echo_ok      = 1'($urandom_range(1));
      e.age_ms       = AGE_W'($urandom);
      e.build_pts_us = build;
      return e;
   endfunction

   task automatic issue(input packet_event_type e);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= e.func;
      req_seq          <= e.seq;
      req_time_us      <= e.time_us;
      req_echo_ok      <= e.echo_ok;
      req_age_ms       <= e.age_ms;
      req_build_pts_us <= e.build_pts_us;
      if (e.func) echo_total++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic retune(input tuning_type t);
      settle();
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      write_reg(CSR_MAX_AGE, CSR_DATA_W'({$urandom, AGE_W'(t.max_age)}));
      write_reg(CSR_NEG_CLAMP, CSR_DATA_W'({$urandom, CLAMP_W'(t.clamp)}));
      write_reg(CSR_MAX_PLAUS, RTT_W'(t.max_plaus));
      write_reg(CSR_ALPHA, CSR_DATA_W'({$urandom, ALPHA_W'(t.alpha)}));
      tuning = t;
   endtask

   initial begin
      tuning_type plan [PHASES];
      packet_event_type e;
      foreach (sent_seq[i]) begin
         sent_seq[i] = '0;
         sent_at[i]  = '0;
      end
      plan[0] = '{1000, -5000, 1000000, 8192, 150};
      plan[1] = '{65535, -1000000, 16777215, 65535, 160};
      plan[2] = '{1, 0, 0, 1, 100};
      plan[3] = '{0, 1048575, 200000, 0, 50};
      plan[4] = '{2000, 1500, 500000, 0, 130};
      plan[5] = '{300, -1048576, 30000, 32768, 180};
      plan[6] = '{1000, -5000, 1000000, 8192, 180};
      tuning = plan[0];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(echo_event(16'd77, '0, 0, 0, '0));
      issue(send_event(16'd0, '0));
      issue(send_event(16'hFFFF, '1));
      issue(send_event(16'd5, 48'd1000));
      issue(echo_event(16'd0, '0, 0, 1500, '0));
      e = echo_event(16'd5, 48'd1000, 10, 200, 48'd1);
      e.echo_ok = 1'b0;
      issue(e);
      issue(echo_event(16'd5, 48'd1000, 1000, 0, 48'd7));
      issue(echo_event(16'd5, 48'd1000, 16'hFFFF, 0, 48'd7));
      issue(echo_event(16'd5, 48'd1000, 0, -1, 48'd7));
      issue(echo_event(16'd5, 48'd1000, 999, -3000, '1));
      issue(echo_event(16'd5, 48'd1000, 999, -5000, 48'd1));
      issue(echo_event(16'd5, 48'd1000, 999, -5001, 48'd1));
      issue(echo_event(16'd5, 48'd1000, 0, 1000000, rand_stamp()));
      issue(echo_event(16'd5, 48'd1000, 0, 1000001, rand_stamp()));
      issue(echo_event(16'hFFFF, '1, 0, 0, 48'd1));
      issue(echo_event(16'hFFFF, '1, 0, 1, 48'd1));
      issue(echo_event(16'd1234, 48'd1000, 0, 10, 48'd1));
      issue(send_event(16'd5, 48'd2000));
      issue(echo_event(16'd5, 48'd1000, 0, 77, '1));
      issue(echo_event(16'd5, 48'd1000, 2, 40, 48'd123));

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) retune(plan[p]);
         calm   <= (p == 1);
         now_us = rand_stamp();
         repeat (plan[p].beats) issue(random_event());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d send and %0d telemetry beats across %0d register settings",
               sent_total, echo_total, PHASES);
      $display("%0d telemetry beats yielded an rtt sample", rtt_samples);
      if (mismatches == 0 && in_flight == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
